// File: rtl/dtsp_pkg.sv
// ---------------------------------------------------------------------------
// dtsp_pkg
// Shared types and constants for the date and time string parser.
// ---------------------------------------------------------------------------
package dtsp_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned FieldW = 8;
  localparam int unsigned CntW   = 3;

  localparam logic [YearW-1:0] DefaultYear  = 16'd2000;
  localparam logic [YearW-1:0] DayLimit     = 16'd31;
  localparam logic [7:0]       CharNul      = 8'h00;
  localparam logic [7:0]       CharZero     = 8'h30;
  localparam logic [7:0]       CharNine     = 8'h39;
  localparam logic [CntW-1:0]  FieldsMax    = 3'd6;
  localparam logic [FieldW-1:0] DefaultMonth = 8'd1;
  localparam logic [FieldW-1:0] DefaultDay   = 8'd1;

  // Field slots, indexed by the count of numbers already completed.
  localparam logic [CntW-1:0] SlotFirst  = 3'd0;
  localparam logic [CntW-1:0] SlotSecond = 3'd1;
  localparam logic [CntW-1:0] SlotThird  = 3'd2;
  localparam logic [CntW-1:0] SlotHour   = 3'd3;
  localparam logic [CntW-1:0] SlotMinute = 3'd4;
  localparam logic [CntW-1:0] SlotSecs   = 3'd5;

  typedef struct packed {
    logic              valid;
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
    logic              complete;
  } dtsp_result_t;

endpackage

// File: rtl/date_time_string_parser_top.sv
// ---------------------------------------------------------------------------
// date_time_string_parser_top
// Parses a NUL-terminated character stream into year, month, day, hour,
// minute and second, and emits one result word per string.
// ---------------------------------------------------------------------------
// A NUL word taken from the input stream passes through the input register
// into the result register, where its result word is offered to the sink.
// Throughput: one character word per cycle; a NUL waits in the input register,
// holding back the words behind it, only while the previous result is untaken.
// Reset: asynchronous and active low; it empties both registers and returns
// the parser to its defaults (year 2000, month and day 1, the rest 0).
module date_time_string_parser_top
  import dtsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata: [7:0] char_byte.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Result stream. tdata: [15:0] year_out, [23:16] month_out,
  // [31:24] day_out, [39:32] hour_out, [47:40] minute_out,
  // [55:48] second_out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  // tuser: [0] complete, set when all six numbers were found.
  output logic [0:0]  m_axis_tuser
);

  logic         byte_valid;
  logic [7:0]   byte_q;
  logic         take;
  logic         out_free;
  dtsp_result_t result;
  dtsp_result_t out_data;

  // The input register frees itself whenever the parser consumes its word.
  dtsp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_byte_i  (s_axis_tdata),
    .take_i    (take),
    .valid_o   (byte_valid),
    .byte_o    (byte_q)
  );

  // The parser updates its number state on every word and forms a result
  // only on the terminating NUL, after which it returns to its defaults.
  dtsp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_q),
    .out_free_i   (out_free),
    .take_o       (take),
    .result_o     (result)
  );

  // The result register decouples the sink so parsing of the next string
  // continues while a finished result waits.
  dtsp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .result_i  (result),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .data_o    (out_data)
  );

  assign m_axis_tdata = {out_data.second, out_data.minute, out_data.hour,
                         out_data.day, out_data.month, out_data.year};
  assign m_axis_tuser = out_data.complete;

endmodule

// File: rtl/dtsp_in_reg.sv
// ---------------------------------------------------------------------------
// dtsp_in_reg
// Input register that holds one character word until the parser takes it.
// ---------------------------------------------------------------------------
module dtsp_in_reg
  import dtsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q,  byte_d;

  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
      byte_d  = s_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// File: rtl/dtsp_core.sv
// ---------------------------------------------------------------------------
// dtsp_core
// Parser state: collects digit runs and forms the result on the NUL byte.
// ---------------------------------------------------------------------------
module dtsp_core
  import dtsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         byte_valid_i,
  input  logic [7:0]   byte_i,
  input  logic         out_free_i,
  output logic         take_o,
  output dtsp_result_t result_o
);

  logic [YearW-1:0]  acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              inside_q, inside_d;
  logic              year_leads_q, year_leads_d;
  logic [YearW-1:0]  first_q, first_d;
  logic [YearW-1:0]  second_q, second_d;
  logic [YearW-1:0]  third_q, third_d;
  logic [FieldW-1:0] hour_q, hour_d;
  logic [FieldW-1:0] minute_q, minute_d;

  logic              is_digit, is_nul;
  logic [3:0]        digit;
  logic [YearW-1:0]  acc_times_ten;

  // Values after the current number is closed by a separator.
  logic [CntW-1:0]   f_cnt;
  logic              f_leads;
  logic [YearW-1:0]  f_first, f_second, f_third;
  logic [FieldW-1:0] f_hour, f_minute;

  assign is_digit      = (byte_i >= CharZero) && (byte_i <= CharNine);
  assign is_nul        = (byte_i == CharNul);
  assign digit         = 4'(byte_i - CharZero);
  assign acc_times_ten = (acc_q << 3) + (acc_q << 1);

  // A NUL byte needs room in the result register; anything else goes through.
  assign take_o = byte_valid_i && (!is_nul || out_free_i);

  always_comb begin
    f_cnt    = cnt_q;
    f_leads  = year_leads_q;
    f_first  = first_q;
    f_second = second_q;
    f_third  = third_q;
    f_hour   = hour_q;
    f_minute = minute_q;
    if (inside_q) begin
      unique case (cnt_q)
        SlotFirst: begin
          f_first = acc_q;
          f_leads = acc_q > DayLimit;
        end
        SlotSecond: f_second = acc_q;
        SlotThird:  f_third  = acc_q;
        SlotHour:   f_hour   = acc_q[FieldW-1:0];
        SlotMinute: f_minute = acc_q[FieldW-1:0];
        default: ;  // the sixth number stays in the accumulator
      endcase
      if (cnt_q < FieldsMax) begin
        f_cnt = cnt_q + 3'd1;
      end
    end
  end

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    inside_d     = inside_q;
    year_leads_d = year_leads_q;
    first_d      = first_q;
    second_d     = second_q;
    third_d      = third_q;
    hour_d       = hour_q;
    minute_d     = minute_q;

    result_o          = '0;
    result_o.valid    = take_o && !is_digit && is_nul;
    result_o.year     = DefaultYear;
    result_o.month    = DefaultMonth;
    result_o.day      = DefaultDay;
    result_o.complete = (f_cnt == FieldsMax);

    if (f_cnt >= 3'd1) begin
      result_o.year = f_first;
    end
    if (f_cnt >= 3'd2) begin
      if (f_leads) begin
        result_o.month = f_second[FieldW-1:0];
        if (f_cnt >= 3'd3) begin
          result_o.day = f_third[FieldW-1:0];
        end
      end else begin
        result_o.month = f_first[FieldW-1:0];
        result_o.day   = f_second[FieldW-1:0];
        result_o.year  = (f_cnt >= 3'd3) ? f_third : DefaultYear;
      end
    end
    if (f_cnt >= 3'd4) result_o.hour   = f_hour;
    if (f_cnt >= 3'd5) result_o.minute = f_minute;
    if (f_cnt >= 3'd6) result_o.second = acc_q[FieldW-1:0];

    if (take_o) begin
      if (is_digit) begin
        if (inside_q) begin
          acc_d = acc_times_ten + YearW'(digit);
        end else if (cnt_q < FieldsMax) begin
          acc_d    = YearW'(digit);
          inside_d = 1'b1;
        end
      end else if (is_nul) begin
        acc_d        = '0;
        cnt_d        = '0;
        inside_d     = 1'b0;
        year_leads_d = 1'b1;
        first_d      = DefaultYear;
        second_d     = '0;
        third_d      = '0;
        hour_d       = '0;
        minute_d     = '0;
      end else begin
        cnt_d        = f_cnt;
        inside_d     = 1'b0;
        year_leads_d = f_leads;
        first_d      = f_first;
        second_d     = f_second;
        third_d      = f_third;
        hour_d       = f_hour;
        minute_d     = f_minute;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      cnt_q        <= '0;
      inside_q     <= 1'b0;
      year_leads_q <= 1'b1;
      first_q      <= DefaultYear;
      second_q     <= '0;
      third_q      <= '0;
      hour_q       <= '0;
      minute_q     <= '0;
    end else begin
      acc_q        <= acc_d;
      cnt_q        <= cnt_d;
      inside_q     <= inside_d;
      year_leads_q <= year_leads_d;
      first_q      <= first_d;
      second_q     <= second_d;
      third_q      <= third_d;
      hour_q       <= hour_d;
      minute_q     <= minute_d;
    end
  end

  a_cnt_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FieldsMax) else $error("field count beyond six");

  a_inside_has_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> (cnt_q < FieldsMax)) else $error("number open with no slot left");

  a_clear_after_nul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && is_nul) |=> (cnt_q == '0 && !inside_q && year_leads_q
                             && first_q == DefaultYear))
    else $error("parser not cleared after end of string");

endmodule

// File: rtl/dtsp_out_reg.sv
// ---------------------------------------------------------------------------
// dtsp_out_reg
// Result register that holds a parsed date word until the sink takes it.
// ---------------------------------------------------------------------------
module dtsp_out_reg
  import dtsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dtsp_result_t result_i,
  output logic         free_o,
  output logic         m_valid_o,
  input  logic         m_ready_i,
  output dtsp_result_t data_o
);

  logic         valid_q, valid_d;
  dtsp_result_t data_q, data_d;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (free_o) begin
      valid_d = result_i.valid;
      data_d  = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_valid_o = valid_q;
  assign data_o    = data_q;

endmodule

// File: tb/sv/date_time_string_parser_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// date_time_string_parser_top_tb
// Self-checking bench for the date and time string parser. A queue of
// character words is built up front: a few hand-picked strings, then random
// date strings with random separators, broken strings and raw noise. A
// clocked driver feeds the queue into the input stream with random gaps, a
// clocked monitor takes result words with random stalls, and a mirror of the
// parser predicts every result word from the accepted characters.
// ---------------------------------------------------------------------------
module date_time_string_parser_top_tb;
  import dtsp_pkg::*;

  localparam int unsigned ItemTarget = 1550;
  // No legal run goes this long without a word moving on either side; the
  // longest quiet stretch is a deliberate receiver hold of HoldCycles.
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned HoldCycles = 300;
  // A NUL word reaches the output by way of the input and result registers.
  localparam int unsigned TailCycles = 8;

  // One predicted result word.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
    logic              complete;
  } date_fields_t;

  // One character word waiting to be sent. When drain is set, the driver
  // holds it back until every predicted date has been taken.
  typedef struct packed {
    bit         drain;
    logic [7:0] ch;
  } char_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  char_word_t   pending_chars[$];
  date_fields_t expected_dates[$];

  // Mirror of the parser state.
  logic [YearW-1:0]  num_acc;
  logic [CntW-1:0]   nums_done;
  logic              in_digits;
  logic              year_first;
  logic [YearW-1:0]  num1;
  logic [YearW-1:0]  num2;
  logic [YearW-1:0]  num3;
  logic [FieldW-1:0] hour_num;
  logic [FieldW-1:0] minute_num;

  int unsigned  chars_sent    = 0;
  int unsigned  dates_checked = 0;
  int unsigned  full_dates    = 0;
  int unsigned  mdy_dates     = 0;
  int unsigned  holds_done    = 0;
  int unsigned  err_cnt       = 0;
  int unsigned  idle_cycles   = 0;
  int unsigned  send_gap      = 0;
  int unsigned  stall_left    = 0;
  int unsigned  hold_left     = 0;
  bit           drain_next    = 1'b0;
  char_word_t   next_word;
  date_fields_t want_date;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  date_time_string_parser_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("date %0d, %s: got %0d, expected %0d",
                             dates_checked, name, got, want));
    end
  endtask

  task automatic clear_parser();
    num_acc    = '0;
    nums_done  = '0;
    in_digits  = 1'b0;
    year_first = 1'b1;
    num1       = DefaultYear;
    num2       = '0;
    num3       = '0;
    hour_num   = '0;
    minute_num = '0;
  endtask

  // Advances the parser mirror by one accepted character and queues the
  // predicted date when the character is the terminating NUL.
  task automatic parse_char(input logic [7:0] ch);
    date_fields_t     d;
    logic [YearW-1:0] digit;
    if (ch >= CharZero && ch <= CharNine) begin
      digit = {8'h00, ch - CharZero};
      if (in_digits) begin
        num_acc = num_acc * 16'd10 + digit;
      end else if (nums_done < FieldsMax) begin
        // Digits after the sixth number never start a new one.
        num_acc   = digit;
        in_digits = 1'b1;
      end
    end else begin
      // Any non-digit, the NUL included, closes a number in progress.
      if (in_digits) begin
        case (nums_done)
          SlotFirst: begin
            num1       = num_acc;
            year_first = num_acc > DayLimit;
          end
          SlotSecond: num2       = num_acc;
          SlotThird:  num3       = num_acc;
          SlotHour:   hour_num   = num_acc[FieldW-1:0];
          SlotMinute: minute_num = num_acc[FieldW-1:0];
          default: ;  // the sixth number stays in the accumulator
        endcase
        if (nums_done < FieldsMax) nums_done++;
        in_digits = 1'b0;
      end
      if (ch == CharNul) begin
        d.year  = DefaultYear;
        d.month = DefaultMonth;
        d.day   = DefaultDay;
        if (nums_done >= 1) d.year = num1;
        if (nums_done >= 2) begin
          if (year_first) begin
            d.month = num2[FieldW-1:0];
            if (nums_done >= 3) d.day = num3[FieldW-1:0];
          end else begin
            d.month = num1[FieldW-1:0];
            d.day   = num2[FieldW-1:0];
            d.year  = (nums_done >= 3) ? num3 : DefaultYear;
            mdy_dates++;
          end
        end
        d.hour     = (nums_done >= 4) ? hour_num : '0;
        d.minute   = (nums_done >= 5) ? minute_num : '0;
        d.second   = (nums_done >= 6) ? num_acc[FieldW-1:0] : '0;
        d.complete = (nums_done == FieldsMax);
        if (d.complete) full_dates++;
        expected_dates.push_back(d);
        clear_parser();
      end
    end
  endtask

  task automatic push_char(input logic [7:0] c);
    char_word_t w;
    w.drain    = drain_next;
    w.ch       = c;
    drain_next = 1'b0;
    pending_chars.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // Usual date punctuation most of the time, otherwise any non-digit,
  // non-NUL byte, high bytes included.
  task automatic push_separator();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = "-";
      1: b = "/";
      2: b = ":";
      3: b = " ";
      4: b = "T";
      5: b = ",";
      6: b = ".";
      default: begin
        b = 8'($urandom_range(1, 255));
        while (b >= CharZero && b <= CharNine) b = 8'($urandom_range(1, 255));
      end
    endcase
    push_char(b);
  endtask

  // Driver: offers the queued character words, one at a time. After each
  // accepted word it draws a random gap, except in one stretch of 128 words
  // out of every 512, where it sends back to back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= CharNul;
      send_gap = 0;
      clear_parser();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata);
        chars_sent++;
        send_gap = (chars_sent[8:7] == 2'd0) ? 0 : $urandom_range(0, 8);
      end
      // A new word may be offered only once the current one has been taken.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].drain && expected_dates.size() != 0)) begin
          next_word = pending_chars.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_word.ch;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result word against the oldest prediction.
  // It stalls for a random gap after each word, not at all for eight words out
  // of every 32, and twice holds tready low for a long stretch so that a
  // second NUL backs up in the input register and stalls the sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dates.size() == 0) begin
          report_error($sformatf("result word %h with no string pending", m_axis_tdata));
        end else begin
          want_date = expected_dates.pop_front();
          check_field("year",     m_axis_tdata[15:0],  want_date.year);
          check_field("month",    16'(m_axis_tdata[23:16]), 16'(want_date.month));
          check_field("day",      16'(m_axis_tdata[31:24]), 16'(want_date.day));
          check_field("hour",     16'(m_axis_tdata[39:32]), 16'(want_date.hour));
          check_field("minute",   16'(m_axis_tdata[47:40]), 16'(want_date.minute));
          check_field("second",   16'(m_axis_tdata[55:48]), 16'(want_date.second));
          check_field("complete", 16'(m_axis_tuser[0]),     16'(want_date.complete));
        end
        dates_checked++;
        stall_left = (dates_checked[4:3] == 2'd0) ? 0 : $urandom_range(0, 8);
        if (dates_checked == 10 || dates_checked == 45) begin
          hold_left = HoldCycles;
          holds_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a run in which no word moves on either side for IdleLimit
  // cycles has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[%0t] ERROR: no word moved for %0d cycles", $realtime, IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned shape;
    int unsigned nums;
    int unsigned strings_made;
    string       txt;

    // Directed strings. An empty string, then only separators (the top
    // byte and the lowest non-zero byte), then a lone number that wraps
    // past 65535, then month and day with no year, then eight numbers with
    // a year first so the last two are dropped. The sender waits for all
    // earlier dates before it starts the last one.
    push_char(CharNul);
    push_char(8'hFF);
    push_char(8'h01);
    push_char(CharNul);
    push_text("99999");
    push_char(CharNul);
    push_text("9/31");
    push_char(CharNul);
    drain_next = 1'b1;
    push_text("32,1,2,3,4,5,6,7");
    push_char(CharNul);

    // Random strings, mostly well formed with six numbers; some have more
    // or fewer numbers, and some are raw noise. Now and then the sender is
    // made to wait for all results before starting a string.
    strings_made = 0;
    while (pending_chars.size() < ItemTarget) begin
      shape      = $urandom_range(0, 9);
      drain_next = (strings_made % 37 == 20);
      if (shape == 9) begin
        repeat ($urandom_range(0, 10)) push_char(8'($urandom_range(1, 255)));
      end else begin
        if (shape <= 5) nums = 6;
        else if (shape == 6) nums = $urandom_range(7, 8);
        else nums = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) push_separator();
        for (int k = 0; k < nums; k++) begin
          if (k > 0) repeat ($urandom_range(1, 2)) push_separator();
          case ($urandom_range(0, 4))
            0: txt = $sformatf("%0d", $urandom_range(0, 31));
            // Around the month-first versus year-first threshold.
            1: txt = $sformatf("%0d", $urandom_range(30, 33));
            2: txt = $sformatf("%0d", $urandom_range(1900, 2099));
            // Raw digit runs: leading zeros and wrap past 16 bits.
            3: begin
              txt = "";
              repeat ($urandom_range(1, 7)) txt = {txt, $sformatf("%0d", $urandom_range(0, 9))};
            end
            default: txt = $sformatf("%0d", $urandom_range(0, 65535));
          endcase
          push_text(txt);
        end
        if ($urandom_range(0, 3) == 0) push_separator();
        // A stray byte of any value; a zero here ends the string early.
        if ($urandom_range(0, 9) == 0) push_char(8'($urandom_range(0, 255)));
      end
      push_char(CharNul);
      strings_made++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || s_axis_tvalid || expected_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d character words in %0d random and 5 directed strings.",
             chars_sent, strings_made);
    $display("Checked %0d dates: %0d complete, %0d month-first, %0d long receiver holds.",
             dates_checked, full_dates, mdy_dates, holds_done);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dtsp_pkg.sv
rtl/dtsp_in_reg.sv
rtl/dtsp_core.sv
rtl/dtsp_out_reg.sv
rtl/date_time_string_parser_top.sv
tb/sv/date_time_string_parser_top_tb.sv
